// ===== design/asc_pkg.sv =====
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants for the Ascon-AEAD128 engine
// Holds the request, kind, status, phase and controller enums, the datapath
// command struct, and the round function helpers.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int unsigned MaxFullBlocks = 4;
  localparam int unsigned BufDepth      = MaxFullBlocks + 1;
  localparam int unsigned BufIdxW       = $clog2(BufDepth);
  localparam int unsigned CntW          = $clog2(BufDepth + 1);

  localparam logic [63:0] AeadIv  = 64'h00001000808c0001;
  localparam logic [63:0] DsepBit = 64'h8000000000000000;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_AD     = 2'd1,
    REQ_MSG    = 2'd2,
    REQ_FINISH = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_TAG    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_SEQ      = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_AD_NONE  = 3'd1,
    PH_AD_OPEN  = 3'd2,
    PH_MSG      = 3'd3,
    PH_MSG_DONE = 3'd4
  } phase_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,      // wait for item
    S_DECODE,    // item captured, classify
    S_PERM,      // run rounds
    S_POST,      // apply post-permutation step
    S_EMIT,      // present one result
    S_REL,       // release buffered plaintext
    S_STAT       // decrypt status result
  } ctrl_e;

  // Datapath operation codes issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,        // load IV/key/nonce
    OP_INIT_POST,   // xor key into lanes 3/4
    OP_AD_ABSORB,   // absorb AD block with padding
    OP_AD_PAD1,     // xor 1 into lane 0 (padding-only AD block)
    OP_DSEP,        // xor domain bit
    OP_MSG_ENC,
    OP_MSG_DEC,
    OP_FIN_PRE,     // final pad and key xor
    OP_FIN_POST,
    OP_ROUND
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] rnd;     // round constant index
    logic       pad;     // message ends here (n < 16)
    logic       msg_pad1;// finish after full/no message
  } dp_cmd_t;

  function automatic logic [63:0] rotr(logic [63:0] x, int unsigned r);
    return (x >> r) | (x << (64 - r));
  endfunction

  function automatic logic [63:0] byte_mask(logic [3:0] k);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(k)) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [63:0] pad_bit(logic [3:0] k);
    logic [63:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (i == int'(k)) p[i*8] = 1'b1;
    end
    return p;
  endfunction

  typedef logic [4:0][63:0] lanes_t;

  function automatic lanes_t ascon_round(lanes_t si, logic [3:0] idx);
    lanes_t s;
    logic [63:0] t0, t1, t2, t3, t4;
    logic [7:0] rc;
    s  = si;
    rc = {4'hF - idx, idx};
    s[2] = s[2] ^ {56'd0, rc};
    s[0] = s[0] ^ s[4]; s[4] = s[4] ^ s[3]; s[2] = s[2] ^ s[1];
    t0 = ~s[0] & s[1]; t1 = ~s[1] & s[2]; t2 = ~s[2] & s[3];
    t3 = ~s[3] & s[4]; t4 = ~s[4] & s[0];
    s[0] = s[0] ^ t1; s[1] = s[1] ^ t2; s[2] = s[2] ^ t3;
    s[3] = s[3] ^ t4; s[4] = s[4] ^ t0;
    s[1] = s[1] ^ s[0]; s[0] = s[0] ^ s[4]; s[3] = s[3] ^ s[2]; s[2] = ~s[2];
    s[0] = s[0] ^ rotr(s[0], 19) ^ rotr(s[0], 28);
    s[1] = s[1] ^ rotr(s[1], 61) ^ rotr(s[1], 39);
    s[2] = s[2] ^ rotr(s[2], 1) ^ rotr(s[2], 6);
    s[3] = s[3] ^ rotr(s[3], 10) ^ rotr(s[3], 17);
    s[4] = s[4] ^ rotr(s[4], 7) ^ rotr(s[4], 41);
    return s;
  endfunction

endpackage

// ===== design/asc_datapath.sv =====
// ----------------------------------------------------------------------------
// asc_datapath: Ascon state, round unit and plaintext buffer
// One permutation round per cycle on the 320-bit state; holds the decrypt
// plaintext buffer, the last ciphertext block and the tag compare.
// ----------------------------------------------------------------------------
module asc_datapath import asc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [63:0]          key_lo_i,
  input  logic [63:0]          key_hi_i,
  input  logic [63:0]          d0_i,
  input  logic [63:0]          d1_i,
  input  logic [4:0]           n_i,
  input  logic                 buf_wr_i,
  input  logic [BufIdxW-1:0]   buf_wr_idx_i,
  input  logic [BufIdxW-1:0]   buf_rd_idx_i,
  output logic [63:0]          ct0_o,
  output logic [63:0]          ct1_o,
  output logic [63:0]          s3_o,
  output logic [63:0]          s4_o,
  output logic                 tag_ok_o,
  output logic [127:0]         buf_data_o,
  output logic [4:0]           buf_len_o
);

  lanes_t      s_q, s_d;
  logic [3:0]  k0, k1;
  logic [63:0] m0, m1, c0, c1;
  logic [63:0] ct0_q, ct1_q;
  logic [127:0] buf_mem [BufDepth];
  logic [4:0]   len_mem [BufDepth];

  assign k0 = (n_i >= 5'd8) ? 4'd8 : n_i[3:0];
  assign k1 = (n_i >= 5'd8) ? 4'(n_i - 5'd8) : 4'd0;
  assign m0 = byte_mask(k0);
  assign m1 = byte_mask(k1);
  assign c0 = d0_i & m0;
  assign c1 = d1_i & m1;

  always_comb begin
    s_d = s_q;
    unique case (cmd_i.op)
      OP_INIT: begin
        s_d[0] = AeadIv; s_d[1] = key_lo_i; s_d[2] = key_hi_i;
        s_d[3] = d0_i;   s_d[4] = d1_i;
      end
      OP_INIT_POST, OP_FIN_POST: begin
        s_d[3] = s_q[3] ^ key_lo_i; s_d[4] = s_q[4] ^ key_hi_i;
      end
      OP_AD_ABSORB, OP_MSG_ENC: begin
        s_d[0] = s_q[0] ^ c0;
        s_d[1] = s_q[1] ^ c1;
        if (cmd_i.pad) begin
          if (n_i < 5'd8) s_d[0] = s_d[0] ^ pad_bit(k0);
          else            s_d[1] = s_d[1] ^ pad_bit(k1);
        end
      end
      OP_MSG_DEC: begin
        s_d[0] = (s_q[0] & ~m0) | c0;
        s_d[1] = (s_q[1] & ~m1) | c1;
        if (cmd_i.pad) begin
          if (n_i < 5'd8) s_d[0] = s_d[0] ^ pad_bit(k0);
          else            s_d[1] = s_d[1] ^ pad_bit(k1);
        end
      end
      OP_AD_PAD1: s_d[0] = s_q[0] ^ 64'd1;
      OP_DSEP:    s_d[4] = s_q[4] ^ DsepBit;
      OP_FIN_PRE: begin
        s_d[0] = s_q[0] ^ {63'd0, cmd_i.msg_pad1};
        s_d[2] = s_q[2] ^ key_lo_i; s_d[3] = s_q[3] ^ key_hi_i;
      end
      OP_ROUND: s_d = ascon_round(s_q, cmd_i.rnd);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s_q <= '0;
    else         s_q <= s_d;
  end

  // Hold the ciphertext of the block just encrypted until its result item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MSG_ENC) begin
      ct0_q <= (s_q[0] ^ c0) & m0;
      ct1_q <= (s_q[1] ^ c1) & m1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_wr_i) begin
      buf_mem[buf_wr_idx_i] <= {(s_q[1] ^ c1) & m1, (s_q[0] ^ c0) & m0};
      len_mem[buf_wr_idx_i] <= n_i;
    end
  end

  assign buf_data_o = buf_mem[buf_rd_idx_i];
  assign buf_len_o  = len_mem[buf_rd_idx_i];
  assign ct0_o = ct0_q;
  assign ct1_o = ct1_q;
  assign s3_o = s_q[3];
  assign s4_o = s_q[4];
  // Compared in the cycle that applies the final key xor.
  assign tag_ok_o = ((s_q[3] ^ key_lo_i) == d0_i) && ((s_q[4] ^ key_hi_i) == d1_i);

endmodule

// ===== design/asc_ctrl.sv =====
// ----------------------------------------------------------------------------
// asc_ctrl: Ascon engine sequencer
// Decodes items against the phase, sequences rounds and result items.
// ----------------------------------------------------------------------------
module asc_ctrl import asc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_i,
  input  logic               dec_i,
  input  logic [4:0]         n_i,
  output logic               cap_o,
  output dp_cmd_t            cmd_o,
  output logic               buf_wr_o,
  output logic [BufIdxW-1:0] buf_wr_idx_o,
  output logic [BufIdxW-1:0] buf_rd_idx_o,
  input  logic               tag_ok_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         res_kind_o,
  output logic [1:0]         res_status_o,
  output logic               res_last_o,
  output logic               res_from_buf_o,
  output logic               res_zero_o,
  output logic               res_state_o
);

  ctrl_e       st_q, st_d;
  phase_e      ph_q, ph_d;
  logic        dir_q, dir_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [3:0]  rnd_q, rnd_d;
  op_e         post_q, post_d;
  logic        fin_q, fin_d;      // permutation belongs to finish
  logic        dsep_q, dsep_d;    // domain separation after post step
  logic        ok_q, ok_d;
  logic [CntW-1:0] rel_q, rel_d;
  logic [1:0]  kind_q, kind_d, stat_q, stat_d;
  logic        rq_q;              // captured: req
  logic [1:0]  req_q;
  logic        dec_q;
  logic [4:0]  nq;
  logic        pend_q, pend_d;    // second permutation pending (close AD then op)
  logic [4:0]  n16;

  assign n16 = (n_i > 5'd16) ? 5'd16 : n_i;

  // The controller captures the item in S_IDLE and keeps a local copy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= REQ_START; dec_q <= 1'b0; nq <= '0; rq_q <= 1'b0;
    end else if (cap_o) begin
      req_q <= req_i; dec_q <= dec_i; nq <= n16; rq_q <= 1'b1;
    end
  end

  assign in_ready_o = (st_q == S_IDLE);
  assign cap_o      = in_valid_i && in_ready_o;

  always_comb begin
    st_d = st_q; ph_d = ph_q; dir_d = dir_q; cnt_d = cnt_q; rnd_d = rnd_q;
    post_d = post_q; fin_d = fin_q; dsep_d = dsep_q; ok_d = ok_q;
    rel_d = rel_q; kind_d = kind_q; stat_d = stat_q; pend_d = pend_q;
    unique case (st_q)
      S_IDLE: if (cap_o) st_d = S_DECODE;
      S_DECODE: begin
        fin_d = 1'b0; dsep_d = 1'b0; pend_d = 1'b0;
        unique case (req_e'(req_q))
          REQ_START: begin
            dir_d = dec_q; ph_d = PH_AD_NONE; cnt_d = '0;
            rnd_d = 4'd0; post_d = OP_INIT_POST; st_d = S_PERM;
          end
          REQ_AD: begin
            if (ph_q != PH_AD_NONE && ph_q != PH_AD_OPEN) begin
              kind_d = KIND_STATUS; stat_d = ST_SEQ; ph_d = PH_IDLE; cnt_d = '0;
              st_d = S_EMIT;
            end else if (ph_q == PH_AD_NONE && nq == 5'd0) begin
              ph_d = PH_MSG; st_d = S_IDLE;
            end else begin
              rnd_d = 4'd4; post_d = OP_NONE; st_d = S_PERM;
              dsep_d = (nq != 5'd16);
              ph_d = (nq == 5'd16) ? PH_AD_OPEN : PH_MSG;
            end
          end
          REQ_MSG, REQ_FINISH: begin
            if (ph_q == PH_IDLE || (req_q == REQ_MSG && ph_q == PH_MSG_DONE)) begin
              kind_d = KIND_STATUS; stat_d = ST_SEQ; ph_d = PH_IDLE; cnt_d = '0;
              st_d = S_EMIT;
            end else if (ph_q == PH_AD_OPEN) begin
              // padding-only AD block, then domain separation
              rnd_d = 4'd4; post_d = OP_NONE; dsep_d = 1'b1; pend_d = 1'b1;
              ph_d = PH_MSG; st_d = S_PERM;
            end else if (ph_q == PH_AD_NONE) begin
              dsep_d = 1'b1; pend_d = 1'b1; ph_d = PH_MSG; st_d = S_POST;
              post_d = OP_NONE;
            end else begin
              pend_d = 1'b1; st_d = S_POST; post_d = OP_NONE;
            end
          end
          default: st_d = S_IDLE;
        endcase
      end
      S_PERM: begin
        if (rnd_q == 4'd11) st_d = S_POST;
        rnd_d = rnd_q + 4'd1;
      end
      S_POST: begin
        if (dsep_q) dsep_d = 1'b0;
        else if (fin_q) begin
          fin_d = 1'b0; ph_d = PH_IDLE;
          if (!dir_q) begin
            kind_d = KIND_TAG; stat_d = ST_OK; cnt_d = '0; st_d = S_EMIT;
          end else begin
            ok_d = tag_ok_i; rel_d = '0;
            st_d = (cnt_q == '0) ? S_STAT : S_REL;
          end
        end else if (pend_q) begin
          pend_d = 1'b0;
          if (req_q == REQ_FINISH) begin
            fin_d = 1'b1; rnd_d = 4'd0; st_d = S_PERM;
          end else if (dir_q) begin
            if ((nq == 5'd16 && cnt_q >= CntW'(MaxFullBlocks)) ||
                cnt_q >= CntW'(BufDepth)) begin
              kind_d = KIND_STATUS; stat_d = ST_OVERFLOW; ph_d = PH_IDLE;
              cnt_d = '0; st_d = S_EMIT;
            end else begin
              cnt_d = cnt_q + 1'b1;
              if (nq == 5'd16) begin rnd_d = 4'd4; st_d = S_PERM; end
              else begin ph_d = PH_MSG_DONE; st_d = S_IDLE; end
            end
          end else begin
            kind_d = KIND_DATA; stat_d = ST_OK;
            if (nq == 5'd16) begin rnd_d = 4'd4; st_d = S_PERM; end
            else begin ph_d = PH_MSG_DONE; st_d = S_EMIT; end
          end
        end else if (post_q == OP_NONE && req_q == REQ_MSG && !dir_q &&
                     rq_q && kind_q == KIND_DATA && stat_q == ST_OK &&
                     nq == 5'd16 && ph_q == PH_MSG) begin
          st_d = S_EMIT;
        end else begin
          st_d = S_IDLE;
        end
      end
      S_EMIT: if (out_ready_i) st_d = S_IDLE;
      S_REL: begin
        if (out_ready_i) begin
          rel_d = rel_q + 1'b1;
          if (rel_q + 1'b1 == cnt_q) st_d = S_STAT;
        end
      end
      S_STAT: if (out_ready_i) begin cnt_d = '0; st_d = S_IDLE; end
      default: st_d = S_IDLE;
    endcase
  end

  // Datapath command, one per cycle.
  always_comb begin
    cmd_o = '{op: OP_NONE, rnd: rnd_q, pad: (nq != 5'd16),
              msg_pad1: (ph_q == PH_MSG)};
    buf_wr_o = 1'b0;
    unique case (st_q)
      S_DECODE: begin
        unique case (req_e'(req_q))
          REQ_START: cmd_o.op = OP_INIT;
          REQ_AD: if ((ph_q == PH_AD_NONE || ph_q == PH_AD_OPEN) &&
                      !(ph_q == PH_AD_NONE && nq == 5'd0)) cmd_o.op = OP_AD_ABSORB;
                  else if (ph_q == PH_AD_NONE) cmd_o.op = OP_DSEP;
          default: if (ph_q == PH_AD_OPEN) cmd_o.op = OP_AD_PAD1;
        endcase
      end
      S_PERM: cmd_o.op = OP_ROUND;
      S_POST: begin
        if (dsep_q) cmd_o.op = OP_DSEP;
        else if (fin_q) cmd_o.op = OP_FIN_POST;
        else if (pend_q) begin
          if (req_q == REQ_FINISH) cmd_o.op = OP_FIN_PRE;
          else if (dir_q) begin
            if (!((nq == 5'd16 && cnt_q >= CntW'(MaxFullBlocks)) ||
                  cnt_q >= CntW'(BufDepth))) begin
              cmd_o.op = OP_MSG_DEC; buf_wr_o = 1'b1;
            end
          end else cmd_o.op = OP_MSG_ENC;
        end else cmd_o.op = post_q;
      end
      default: ;
    endcase
  end

  assign buf_wr_idx_o = cnt_q[BufIdxW-1:0];
  assign buf_rd_idx_o = rel_q[BufIdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ph_q <= PH_IDLE; dir_q <= 1'b0; cnt_q <= '0;
      rnd_q <= '0; post_q <= OP_NONE; fin_q <= 1'b0; dsep_q <= 1'b0;
      ok_q <= 1'b0; rel_q <= '0; kind_q <= KIND_DATA; stat_q <= ST_OK;
      pend_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; dir_q <= dir_d; cnt_q <= cnt_d;
      rnd_q <= rnd_d; post_q <= post_d; fin_q <= fin_d; dsep_q <= dsep_d;
      ok_q <= ok_d; rel_q <= rel_d; kind_q <= kind_d; stat_q <= stat_d;
      pend_q <= pend_d;
    end
  end

  // Result item control.
  always_comb begin
    out_valid_o    = 1'b0;
    res_kind_o     = kind_q;
    res_status_o   = stat_q;
    res_last_o     = 1'b1;
    res_from_buf_o = 1'b0;
    res_zero_o     = 1'b0;
    res_state_o    = 1'b0;
    unique case (st_q)
      S_EMIT: begin
        out_valid_o = 1'b1;
        res_state_o = (kind_q != KIND_STATUS);
      end
      S_REL: begin
        out_valid_o = 1'b1; res_kind_o = KIND_DATA; res_status_o = ST_OK;
        res_last_o = 1'b0; res_from_buf_o = 1'b1; res_zero_o = !ok_q;
      end
      S_STAT: begin
        out_valid_o = 1'b1; res_kind_o = KIND_STATUS;
        res_status_o = ok_q ? ST_OK : ST_MISMATCH;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(BufDepth)) else $error("buffer count out of range");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while presenting result");
  a_rel_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_REL) |-> (rel_q < cnt_q)) else $error("release index overrun");
`endif

endmodule

// ===== design/ascon_aead128_engine.sv =====
// ----------------------------------------------------------------------------
// ascon_aead128_engine: streaming Ascon-AEAD128 encrypt/decrypt engine
// Key from two config registers, items in, data/tag/status items out.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tdata {byte_count, data_hi, data_lo, decrypt, req_type}
//  m_axis    out  tdata {last, status, out_bytes, out_hi, out_lo, out_kind}
//  cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i (key_low, key_high)
//
// Start and finish take 12 rounds; AD and full message blocks take 8 rounds,
// one round per cycle through the round unit.
// Decrypt finish then releases one buffered block per accepted output item.
// One item is in work at a time; tready is low until its results are taken.
// Reset clears the state, phase and counts; the plaintext buffer is not reset.
module ascon_aead128_engine import asc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] req_type, [2] decrypt, [66:3] data_lo, [130:67] data_hi,
  // [135:131] byte_count
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] out_kind, [65:2] out_lo, [129:66] out_hi, [134:130] out_bytes,
  // [136:135] status, [137] last
  output logic [143:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);

  logic [63:0]  key_lo_q, key_hi_q;
  logic [63:0]  d0_q, d1_q;
  logic [4:0]   n_q;
  logic         cap;
  dp_cmd_t      cmd;
  logic         buf_wr, tag_ok;
  logic [BufIdxW-1:0] wr_idx, rd_idx;
  logic [63:0]  ct0, ct1, s3, s4;
  logic [127:0] bdata;
  logic [4:0]   blen;
  logic [1:0]   rkind, rstat;
  logic         rlast, rbuf, rzero, rstate;
  logic [63:0]  olo, ohi;
  logic [4:0]   obytes;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0; key_hi_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 1'b0) key_lo_q <= cfg_data_i;
      else                   key_hi_q <= cfg_data_i;
    end
  end

  // Hold the accepted item's payload.
  always_ff @(posedge clk_i) begin
    if (cap) begin
      d0_q <= s_axis_tdata[66:3];
      d1_q <= s_axis_tdata[130:67];
      n_q  <= (s_axis_tdata[135:131] > 5'd16) ? 5'd16 : s_axis_tdata[135:131];
    end
  end

  asc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .req_i(s_axis_tdata[1:0]), .dec_i(s_axis_tdata[2]), .n_i(s_axis_tdata[135:131]),
    .cap_o(cap), .cmd_o(cmd), .buf_wr_o(buf_wr), .buf_wr_idx_o(wr_idx),
    .buf_rd_idx_o(rd_idx), .tag_ok_i(tag_ok),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .res_kind_o(rkind), .res_status_o(rstat), .res_last_o(rlast),
    .res_from_buf_o(rbuf), .res_zero_o(rzero), .res_state_o(rstate)
  );

  asc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .key_lo_i(key_lo_q), .key_hi_i(key_hi_q),
    .d0_i(d0_q), .d1_i(d1_q), .n_i(n_q), .buf_wr_i(buf_wr),
    .buf_wr_idx_i(wr_idx), .buf_rd_idx_i(rd_idx),
    .ct0_o(ct0), .ct1_o(ct1), .s3_o(s3), .s4_o(s4), .tag_ok_o(tag_ok),
    .buf_data_o(bdata), .buf_len_o(blen)
  );

  // Select the result payload. Encrypt data comes from the ciphertext
  // register, loaded at absorb time, so a full block is still right after
  // its permutation has run.
  always_comb begin
    olo = '0; ohi = '0; obytes = '0;
    if (rbuf) begin
      olo = rzero ? 64'd0 : bdata[63:0];
      ohi = rzero ? 64'd0 : bdata[127:64];
      obytes = blen;
    end else if (rstate) begin
      if (rkind == KIND_TAG) begin
        olo = s3; ohi = s4; obytes = 5'd16;
      end else begin
        olo = ct0; ohi = ct1; obytes = n_q;
      end
    end
  end

  assign m_axis_tdata = {6'd0, rlast, rstat, obytes, ohi, olo, rkind};

`ifndef SYNTHESIS
  a_out_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == KIND_TAG) |-> m_axis_tdata[137])
    else $error("tag item without last");
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("accept during result");
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == KIND_STATUS) |-> m_axis_tdata[134:2] == '0)
    else $error("status item carries data");
`endif

endmodule
